[rtl/core/otmr_pkg.sv]
// shared types and codes of the one-shot timer table
`timescale 1ns / 1ps

package otmr_pkg;

   localparam int MAX_OUT   = 16;
   localparam int HIT_W     = $clog2(MAX_OUT + 1);
   localparam int COUNT_W   = 33;
   localparam int TAG_W     = 32;
   localparam int TIME_W    = 32;
   localparam int SLOT_W    = 8;

   typedef enum logic [1:0] {
      ACT_CREATE  = 2'd0,
      ACT_DESTROY = 2'd1,
      ACT_FIND    = 2'd2,
      ACT_TICK    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_ID    = 2'd1,
      STAT_BAD_MODE  = 2'd2,
      STAT_BAD_OWNER = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_DEAD  = 2'd0,
      MODE_TICKS = 2'd1,
      MODE_SECS  = 2'd2
   } mode_type;

   // count_mode codes on the request word
   localparam logic [1:0] CNT_TICKS = 2'd0;
   localparam logic [1:0] CNT_SECS  = 2'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_TICK,
      S_TICK_END
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TAG_W-1:0]   owner;
   } entry_type;

   typedef struct packed {
      logic               expire;
      logic               count_wr;
      logic [COUNT_W-1:0] next_count;
   } eval_type;

endpackage

[rtl/core/otmr_ifs.sv]
// request and response channel interfaces of the timer table
`timescale 1ns / 1ps

interface otmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  timer_id;
   logic [31:0] delay_value;
   logic [1:0]  count_mode;
   logic [31:0] owner_tag;
   logic        owner_ok;
   logic [31:0] now_seconds;

   modport source (
      output valid, action, timer_id, delay_value, count_mode, owner_tag, owner_ok,
             now_seconds,
      input  ready
   );
   modport sink (
      input  valid, action, timer_id, delay_value, count_mode, owner_tag, owner_ok,
             now_seconds,
      output ready
   );
endinterface

interface otmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  slot_out;
   logic        fired;
   logic [31:0] fired_tag;
   logic        last;

   modport source (
      output valid, status, slot_out, fired, fired_tag, last,
      input  ready
   );
   modport sink (
      input  valid, status, slot_out, fired, fired_tag, last,
      output ready
   );
endinterface

[rtl/core/otmr_slot_eval.sv]
// expiry test and count update for one slot during a tick
`timescale 1ns / 1ps

module otmr_slot_eval (
   input  otmr_pkg::mode_type              mode,
   input  otmr_pkg::entry_type             entry,
   input  logic [otmr_pkg::TIME_W-1:0]     now,
   output otmr_pkg::eval_type              eval
);

   always_comb begin
      eval.expire     = 1'b0;
      eval.count_wr   = 1'b0;
      eval.next_count = entry.count - otmr_pkg::COUNT_W'(1);
      case (mode)
         otmr_pkg::MODE_TICKS: begin
            // zero and one both fire on this tick
            if (entry.count <= otmr_pkg::COUNT_W'(1)) begin
               eval.expire = 1'b1;
            end else begin
               eval.count_wr = 1'b1;
            end
         end
         otmr_pkg::MODE_SECS: begin
            eval.expire = (entry.count <= {1'b0, now});
         end
         default: begin
            eval.expire   = 1'b0;
            eval.count_wr = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/one_shot_timer_table.sv]
// top level of the one-shot timer table
`timescale 1ns / 1ps

// Table of NUM_TIMERS one-shot timers, driven by request words on req_if.
// Each request word carries one action: create, destroy, find-free or tick.
// Create, destroy and find-free give one response word; a tick gives one
// word per expiring timer (at most sixteen, last set on the final one), or
// a single word with fired clear when nothing expires.
// For create and destroy the response is registered the cycle after the
// request is taken. Find-free walks the mode flops one slot a cycle. A
// tick walks the count/owner RAM one slot a cycle while its walk is not
// paused, its registered read issued a slot ahead.
// One request is in work at a time; the next is taken once the current
// one has handed its final word to the output register.
// A response waits in the output register while rsp_if.ready is low; a tick
// keeps at most one further expiry in a holding register and pauses its
// walk when both are full.
// Reset marks every slot dead at once; the RAM needs no clearing.
module one_shot_timer_table #(
   parameter int NUM_TIMERS = 16
) (
   input  logic          clock,
   input  logic          reset,
   otmr_req_if.sink      req_if,
   otmr_rsp_if.source    rsp_if
);

   localparam int IDW        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int MODE_DEPTH = 1 << IDW;

   otmr_pkg::state_type state_ff, state_in;
   logic [IDW-1:0]      idx_ff, idx_in;
   logic [otmr_pkg::HIT_W-1:0]  hits_ff, hits_in;
   logic [otmr_pkg::TIME_W-1:0] now_ff, now_in;

   otmr_pkg::mode_type  mode_ff [MODE_DEPTH];
   otmr_pkg::entry_type mem [NUM_TIMERS];
   otmr_pkg::entry_type rdata_ff;

   logic                        pend_valid_ff, pend_valid_in;
   logic [otmr_pkg::SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [otmr_pkg::TAG_W-1:0]  pend_tag_ff, pend_tag_in;

   logic                        out_valid_ff, out_valid_in;
   otmr_pkg::status_type        out_status_ff, out_status_in;
   logic [otmr_pkg::SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic                        out_fired_ff, out_fired_in;
   logic [otmr_pkg::TAG_W-1:0]  out_tag_ff, out_tag_in;
   logic                        out_last_ff, out_last_in;

   logic                accept;
   logic                out_can_load;
   logic                out_load;
   logic                id_in_range;
   logic [IDW-1:0]      req_idx;
   logic [IDW-1:0]      mode_idx;
   otmr_pkg::mode_type  sel_mode;
   logic                idx_last;
   logic                find_hit;
   logic                tick_stall;
   logic                tick_done;
   otmr_pkg::eval_type  ev;

   logic                mem_we;
   logic [IDW-1:0]      mem_waddr;
   otmr_pkg::entry_type mem_wdata;
   logic                rd_en;
   logic [IDW-1:0]      raddr;
   logic                mode_we;
   logic [IDW-1:0]      mode_waddr;
   otmr_pkg::mode_type  mode_wdata;

   assign out_can_load  = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == otmr_pkg::S_IDLE) && out_can_load;
   assign accept        = req_if.valid && req_if.ready;
   assign id_in_range   = (req_if.timer_id < otmr_pkg::SLOT_W'(NUM_TIMERS));
   assign req_idx       = req_if.timer_id[IDW-1:0];
   assign mode_idx      = (state_ff == otmr_pkg::S_IDLE) ? req_idx : idx_ff;
   assign sel_mode      = mode_ff[mode_idx];
   assign idx_last      = (idx_ff == IDW'(NUM_TIMERS - 1));
   assign find_hit      = (sel_mode == otmr_pkg::MODE_DEAD);
   assign tick_stall    = ev.expire && pend_valid_ff && !out_can_load;
   assign tick_done     = (ev.expire && (hits_ff == otmr_pkg::HIT_W'(otmr_pkg::MAX_OUT - 1)))
                          || idx_last;

   otmr_slot_eval u_eval (
      .mode  (sel_mode),
      .entry (rdata_ff),
      .now   (now_ff),
      .eval  (ev)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         otmr_pkg::S_IDLE: begin
            if (accept) begin
               if (otmr_pkg::action_type'(req_if.action) == otmr_pkg::ACT_FIND) begin
                  state_in = otmr_pkg::S_FIND;
               end else if (otmr_pkg::action_type'(req_if.action) == otmr_pkg::ACT_TICK) begin
                  state_in = otmr_pkg::S_TICK;
               end
            end
         end
         otmr_pkg::S_FIND: begin
            if ((find_hit || idx_last) && out_can_load) begin
               state_in = otmr_pkg::S_IDLE;
            end
         end
         otmr_pkg::S_TICK: begin
            if (!tick_stall && tick_done) begin
               state_in = otmr_pkg::S_TICK_END;
            end
         end
         otmr_pkg::S_TICK_END: begin
            if (out_can_load) begin
               state_in = otmr_pkg::S_IDLE;
            end
         end
         default: state_in = otmr_pkg::S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      idx_in        = idx_ff;
      hits_in       = hits_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      out_load      = 1'b0;
      out_status_in = otmr_pkg::STAT_OK;
      out_slot_in   = '0;
      out_fired_in  = 1'b0;
      out_tag_in    = '0;
      out_last_in   = 1'b1;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = rdata_ff;
      rd_en         = 1'b0;
      raddr         = IDW'(idx_ff + IDW'(1));
      mode_we       = 1'b0;
      mode_waddr    = idx_ff;
      mode_wdata    = otmr_pkg::MODE_DEAD;

      unique case (state_ff)
         otmr_pkg::S_IDLE: begin
            if (accept) begin
               unique case (otmr_pkg::action_type'(req_if.action))
                  otmr_pkg::ACT_CREATE: begin
                     out_load = 1'b1;
                     if (!id_in_range || sel_mode != otmr_pkg::MODE_DEAD) begin
                        out_status_in = otmr_pkg::STAT_BAD_ID;
                     end else if (req_if.count_mode != otmr_pkg::CNT_TICKS &&
                                  req_if.count_mode != otmr_pkg::CNT_SECS) begin
                        out_status_in = otmr_pkg::STAT_BAD_MODE;
                     end else if (!req_if.owner_ok) begin
                        out_status_in = otmr_pkg::STAT_BAD_OWNER;
                     end else begin
                        mem_we          = 1'b1;
                        mem_waddr       = req_idx;
                        mem_wdata.owner = req_if.owner_tag;
                        mode_we         = 1'b1;
                        mode_waddr      = req_idx;
                        if (req_if.count_mode == otmr_pkg::CNT_TICKS) begin
                           mem_wdata.count = {1'b0, req_if.delay_value};
                           mode_wdata      = otmr_pkg::MODE_TICKS;
                        end else begin
                           // absolute deadline, one bit wider so it never wraps
                           mem_wdata.count = {1'b0, req_if.now_seconds}
                                             + {1'b0, req_if.delay_value};
                           mode_wdata      = otmr_pkg::MODE_SECS;
                        end
                     end
                  end
                  otmr_pkg::ACT_DESTROY: begin
                     out_load = 1'b1;
                     if (id_in_range) begin
                        mode_we    = 1'b1;
                        mode_waddr = req_idx;
                        mode_wdata = otmr_pkg::MODE_DEAD;
                     end else begin
                        out_status_in = otmr_pkg::STAT_BAD_ID;
                     end
                  end
                  otmr_pkg::ACT_FIND: begin
                     idx_in = '0;
                  end
                  otmr_pkg::ACT_TICK: begin
                     idx_in        = '0;
                     hits_in       = '0;
                     now_in        = req_if.now_seconds;
                     pend_valid_in = 1'b0;
                     rd_en         = 1'b1;
                     raddr         = '0;
                  end
                  default: begin
                     idx_in = idx_ff;
                  end
               endcase
            end
         end
         otmr_pkg::S_FIND: begin
            if (find_hit) begin
               out_load    = out_can_load;
               out_slot_in = otmr_pkg::SLOT_W'(idx_ff);
            end else if (idx_last) begin
               out_load      = out_can_load;
               out_status_in = otmr_pkg::STAT_BAD_ID;
            end else begin
               idx_in = IDW'(idx_ff + IDW'(1));
            end
         end
         otmr_pkg::S_TICK: begin
            if (!tick_stall) begin
               if (ev.count_wr) begin
                  mem_we          = 1'b1;
                  mem_wdata.count = ev.next_count;
               end
               if (ev.expire) begin
                  mode_we = 1'b1;
                  hits_in = otmr_pkg::HIT_W'(hits_ff + otmr_pkg::HIT_W'(1));
                  // the held expiry is not the last one, release it
                  if (pend_valid_ff) begin
                     out_load      = 1'b1;
                     out_slot_in   = pend_slot_ff;
                     out_fired_in  = 1'b1;
                     out_tag_in    = pend_tag_ff;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = otmr_pkg::SLOT_W'(idx_ff);
                  pend_tag_in   = rdata_ff.owner;
               end
               if (!tick_done) begin
                  idx_in = IDW'(idx_ff + IDW'(1));
                  rd_en  = 1'b1;
               end
            end
         end
         otmr_pkg::S_TICK_END: begin
            if (out_can_load) begin
               out_load      = 1'b1;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  out_slot_in  = pend_slot_ff;
                  out_fired_in = 1'b1;
                  out_tag_in   = pend_tag_ff;
               end
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   assign out_valid_in = out_load || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= otmr_pkg::S_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         hits_ff       <= '0;
         idx_ff        <= '0;
         for (int i = 0; i < MODE_DEPTH; i++) begin
            mode_ff[i] <= otmr_pkg::MODE_DEAD;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         hits_ff       <= hits_in;
         idx_ff        <= idx_in;
         if (mode_we) begin
            mode_ff[mode_waddr] <= mode_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_slot_ff   <= out_slot_in;
         out_fired_ff  <= out_fired_in;
         out_tag_ff    <= out_tag_in;
         out_last_ff   <= out_last_in;
      end
   end

   // count and owner RAM, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.status    = out_status_ff;
   assign rsp_if.slot_out  = out_slot_ff;
   assign rsp_if.fired     = out_fired_ff;
   assign rsp_if.fired_tag = out_tag_ff;
   assign rsp_if.last      = out_last_ff;

endmodule

[sim/otmr_tb_pkg.sv]
// shadow copy of the timer table with its response word checker
`timescale 1ns / 1ps

package otmr_tb_pkg;
   import otmr_pkg::*;

   localparam int NUM_SLOTS = 16;

   typedef struct {
      action_type  action;
      logic [7:0]  timer_id;
      logic [31:0] delay_value;
      logic [1:0]  count_mode;
      logic [31:0] owner_tag;
      logic        owner_ok;
      logic [31:0] now_seconds;
   } command_type;

   typedef struct {
      status_type  status;
      logic [7:0]  slot_out;
      logic        fired;
      logic [31:0] fired_tag;
      logic        last;
   } reply_type;

   class timer_table_shadow;
      mode_type           slot_mode  [NUM_SLOTS];
      logic [COUNT_W-1:0] slot_count [NUM_SLOTS];
      logic [TAG_W-1:0]   slot_owner [NUM_SLOTS];
      reply_type          due_words  [$];
      int                 mismatches;
      int                 action_seen [4];
      int                 timers_fired;
      int                 widest_burst;

      function new();
         foreach (slot_mode[i]) slot_mode[i] = MODE_DEAD;
         foreach (action_seen[i]) action_seen[i] = 0;
         mismatches   = 0;
         timers_fired = 0;
         widest_burst = 0;
      endfunction

      // advances the table by one accepted command and queues the words it owes
      function void take_command(command_type c);
         reply_type word;
         int        expired [$];
         int        id;
         int        i;
         id   = int'(c.timer_id);
         word = '{status: STAT_OK, slot_out: 8'd0, fired: 1'b0, fired_tag: 32'd0, last: 1'b1};
         action_seen[int'(c.action)]++;
         case (c.action)
            ACT_CREATE: begin
               if (id >= NUM_SLOTS)
                  word.status = STAT_BAD_ID;
               else if (slot_mode[id] != MODE_DEAD)
                  word.status = STAT_BAD_ID;
               else if (c.count_mode != CNT_TICKS && c.count_mode != CNT_SECS)
                  word.status = STAT_BAD_MODE;
               else if (!c.owner_ok)
                  word.status = STAT_BAD_OWNER;
               else begin
                  slot_owner[id] = c.owner_tag;
                  if (c.count_mode == CNT_TICKS) begin
                     slot_mode[id]  = MODE_TICKS;
                     slot_count[id] = {1'b0, c.delay_value};
                  end else begin
                     // deadline is 33 bits wide, so it never wraps
                     slot_mode[id]  = MODE_SECS;
                     slot_count[id] = {1'b0, c.now_seconds} + {1'b0, c.delay_value};
                  end
               end
               due_words.push_back(word);
            end
            ACT_DESTROY: begin
               if (id < NUM_SLOTS)
                  slot_mode[id] = MODE_DEAD;
               else
                  word.status = STAT_BAD_ID;
               due_words.push_back(word);
            end
            ACT_FIND: begin
               // walk downwards so the lowest dead slot is the one kept
               word.status = STAT_BAD_ID;
               for (i = NUM_SLOTS - 1; i >= 0; i--) begin
                  if (slot_mode[i] == MODE_DEAD) begin
                     word.status   = STAT_OK;
                     word.slot_out = 8'(i);
                  end
               end
               due_words.push_back(word);
            end
            default: begin
               for (i = 0; i < NUM_SLOTS && expired.size() < MAX_OUT; i++) begin
                  if (slot_mode[i] == MODE_TICKS) begin
                     // a count of zero fires just like a count of one
                     if (slot_count[i] <= 1)
                        expired.push_back(i);
                     else
                        slot_count[i] = slot_count[i] - 1;
                  end else if (slot_mode[i] == MODE_SECS &&
                               slot_count[i] <= {1'b0, c.now_seconds}) begin
                     expired.push_back(i);
                  end
               end
               foreach (expired[k]) begin
                  slot_mode[expired[k]] = MODE_DEAD;
                  word.fired     = 1'b1;
                  word.slot_out  = 8'(expired[k]);
                  word.fired_tag = slot_owner[expired[k]];
                  word.last      = (k == expired.size() - 1);
                  due_words.push_back(word);
               end
               if (expired.size() == 0)
                  due_words.push_back(word);
               timers_fired += expired.size();
               if (expired.size() > widest_burst)
                  widest_burst = expired.size();
            end
         endcase
      endfunction

      function void match_word(reply_type got);
         reply_type want;
         if (due_words.size() == 0) begin
            $error("response word with nothing due: slot_out %0d fired %0b fired_tag %h",
                   got.slot_out, got.fired, got.fired_tag);
            mismatches++;
            return;
         end
         want = due_words.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
            mismatches++;
         end
         if (got.fired !== want.fired) begin
            $error("fired: expected %0b, actual %0b", want.fired, got.fired);
            mismatches++;
         end
         if (got.fired_tag !== want.fired_tag) begin
            $error("fired_tag: expected %h, actual %h", want.fired_tag, got.fired_tag);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
         end
      endfunction

      function int words_due();
         return due_words.size();
      endfunction
   endclass

endpackage

[sim/one_shot_timer_table_tb.sv]
// testbench of the one-shot timer table: directed corners, then random traffic
`timescale 1ns / 1ps

module one_shot_timer_table_tb;
   import otmr_pkg::*;
   import otmr_tb_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int TAIL_CYCLES  = NUM_SLOTS + 8;
   localparam int RANDOM_WORDS = 70;

   // count_mode codes the block must refuse
   localparam logic [1:0] CNT_RESERVED_LO = 2'd2;
   localparam logic [1:0] CNT_RESERVED_HI = 2'd3;

   logic        clock;
   logic        reset;
   logic        quiet_req;
   logic        quiet_rsp;
   logic [31:0] secs_now;
   int          idle_cycles = 0;

   timer_table_shadow shadow = new();

   otmr_req_if req_if ();
   otmr_rsp_if rsp_if ();

   one_shot_timer_table #(
      .NUM_TIMERS(NUM_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : monitor
      reply_type   seen_word;
      command_type seen_cmd;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen_word.status    = status_type'(rsp_if.status);
            seen_word.slot_out  = rsp_if.slot_out;
            seen_word.fired     = rsp_if.fired;
            seen_word.fired_tag = rsp_if.fired_tag;
            seen_word.last      = rsp_if.last;
            shadow.match_word(seen_word);
         end
         if (req_if.valid && req_if.ready) begin
            seen_cmd.action      = action_type'(req_if.action);
            seen_cmd.timer_id    = req_if.timer_id;
            seen_cmd.delay_value = req_if.delay_value;
            seen_cmd.count_mode  = req_if.count_mode;
            seen_cmd.owner_tag   = req_if.owner_tag;
            seen_cmd.owner_ok    = req_if.owner_ok;
            seen_cmd.now_seconds = req_if.now_seconds;
            shadow.take_command(seen_cmd);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // response side: random stalls, with quiet stretches
   initial begin : response_sink
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = quiet_rsp ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   function automatic command_type make_cmd(action_type act, logic [7:0] id,
                                            logic [31:0] delay, logic [1:0] mode,
                                            logic [31:0] tag, logic ok, logic [31:0] now);
      command_type c;
      c.action      = act;
      c.timer_id    = id;
      c.delay_value = delay;
      c.count_mode  = mode;
      c.owner_tag   = tag;
      c.owner_ok    = ok;
      c.now_seconds = now;
      return c;
   endfunction

   task automatic send_cmd(input command_type c);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.action      <= c.action;
      req_if.timer_id    <= c.timer_id;
      req_if.delay_value <= c.delay_value;
      req_if.count_mode  <= c.count_mode;
      req_if.owner_tag   <= c.owner_tag;
      req_if.owner_ok    <= c.owner_ok;
      req_if.now_seconds <= c.now_seconds;
      req_if.valid       <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // stop sending until every owed word has come back
   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (shadow.words_due() != 0);
      @(posedge clock);
   endtask

   task automatic random_traffic();
      command_type c;
      int          n;
      int          s;
      int          pick;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 16 == 0) begin
            quiet_req = ($urandom_range(0, 3) == 0);
            quiet_rsp = ($urandom_range(0, 3) == 0);
         end
         if (n == 40) begin
            // rebuild the whole table so that one tick expires every slot
            for (s = 0; s < NUM_SLOTS; s++) begin
               send_cmd(make_cmd(ACT_DESTROY, 8'(s), $urandom, CNT_TICKS, $urandom, 1'b1,
                                 secs_now));
               send_cmd(make_cmd(ACT_CREATE, 8'(s), 32'($urandom_range(0, 1)), CNT_TICKS,
                                 $urandom, 1'b1, secs_now));
            end
            send_cmd(make_cmd(ACT_TICK, 8'd0, 32'd0, CNT_TICKS, 32'd0, 1'b1, secs_now));
         end
         if (n == 60)
            hold_until_drained();
         pick          = $urandom_range(0, 99);
         c.owner_tag   = $urandom;
         c.owner_ok    = ($urandom_range(0, 11) != 0);
         c.timer_id    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, NUM_SLOTS - 1));
         c.count_mode  = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(0, 3))
                                                      : 2'($urandom_range(0, 1));
         if ($urandom_range(0, 11) == 0)
            c.delay_value = $urandom;
         else if (c.count_mode == CNT_SECS)
            c.delay_value = $urandom_range(0, 20);
         else
            c.delay_value = $urandom_range(0, 6);
         if (pick < 40)
            c.action = ACT_CREATE;
         else if (pick < 52)
            c.action = ACT_DESTROY;
         else if (pick < 62)
            c.action = ACT_FIND;
         else begin
            c.action = ACT_TICK;
            secs_now = secs_now + $urandom_range(0, 4);
         end
         c.now_seconds = secs_now;
         send_cmd(c);
      end
   endtask

   initial begin : stimulus
      int          i;
      logic [31:0] dly;
      logic [31:0] tag;
      logic [31:0] now;
      logic [1:0]  mode;
      req_if.valid       <= 1'b0;
      req_if.action      <= ACT_CREATE;
      req_if.timer_id    <= 8'd0;
      req_if.delay_value <= 32'd0;
      req_if.count_mode  <= CNT_TICKS;
      req_if.owner_tag   <= 32'd0;
      req_if.owner_ok    <= 1'b0;
      req_if.now_seconds <= 32'd0;
      reset              <= 1'b1;
      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
      secs_now  = $urandom_range(0, 1000);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // refused creates: id past the table, reserved modes, missing owner
      send_cmd(make_cmd(ACT_CREATE, 8'd16, 32'd3, CNT_TICKS, 32'h1234_5678, 1'b1, 32'd0));
      send_cmd(make_cmd(ACT_CREATE, 8'd255, 32'd3, CNT_TICKS, 32'h1234_5678, 1'b1, 32'd0));
      send_cmd(make_cmd(ACT_CREATE, 8'd3, 32'd3, CNT_RESERVED_LO, 32'h5555_aaaa, 1'b1, 32'd0));
      // mode is judged before the owner flag
      send_cmd(make_cmd(ACT_CREATE, 8'd3, 32'd3, CNT_RESERVED_HI, 32'h5555_aaaa, 1'b0, 32'd0));
      send_cmd(make_cmd(ACT_CREATE, 8'd3, 32'd3, CNT_TICKS, 32'h5555_aaaa, 1'b0, 32'd0));
      send_cmd(make_cmd(ACT_DESTROY, 8'd200, 32'd0, CNT_TICKS, 32'd0, 1'b1, 32'd0));
      send_cmd(make_cmd(ACT_DESTROY, 8'd5, 32'd0, CNT_TICKS, 32'd0, 1'b1, 32'd0));

      // fill the table, with the corner delays in the low slots
      for (i = 0; i < NUM_SLOTS; i++) begin
         mode = CNT_TICKS;
         tag  = $urandom;
         now  = 32'd0;
         dly  = $urandom_range(3, 6);
         case (i)
            0: begin
               dly = 32'd0;
               tag = 32'd0;
            end
            1: begin
               dly = 32'd1;
               tag = 32'hffff_ffff;
            end
            2: dly = 32'hffff_ffff;
            3: begin
               // deadline beyond any 32-bit time
               mode = CNT_SECS;
               now  = 32'hffff_ffff;
               dly  = 32'hffff_ffff;
            end
            4: begin
               mode = CNT_SECS;
               dly  = 32'd50;
            end
            default: ;
         endcase
         send_cmd(make_cmd(ACT_CREATE, 8'(i), dly, mode, tag, 1'b1, now));
      end
      send_cmd(make_cmd(ACT_CREATE, 8'd7, 32'd2, CNT_TICKS, 32'h0f0f_0f0f, 1'b1, 32'd0));
      send_cmd(make_cmd(ACT_FIND, 8'd0, 32'd0, CNT_TICKS, 32'd0, 1'b1, 32'd0));
      send_cmd(make_cmd(ACT_TICK, 8'd0, 32'd0, CNT_TICKS, 32'd0, 1'b1, 32'd60));
      send_cmd(make_cmd(ACT_TICK, 8'd0, 32'd0, CNT_TICKS, 32'd0, 1'b1, 32'hffff_ffff));
      send_cmd(make_cmd(ACT_FIND, 8'd0, 32'd0, CNT_TICKS, 32'd0, 1'b1, 32'd0));
      hold_until_drained();

      random_traffic();
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d creates, %0d destroys, %0d free-slot searches, %0d ticks",
               shadow.action_seen[ACT_CREATE], shadow.action_seen[ACT_DESTROY],
               shadow.action_seen[ACT_FIND], shadow.action_seen[ACT_TICK]);
      $display("%0d timers expired, up to %0d in one tick; %0d mismatches",
               shadow.timers_fired, shadow.widest_burst, shadow.mismatches);
      if (shadow.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
